// ===== design/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// pst_pkg: shared types and constants
// Holds the sizes, the operation codes and the control struct that the
// sequencer sends to the element unit.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int VAL_W        = 64;
	localparam int WORD_W       = VAL_W + 1;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_INC   = 2'd1;
	localparam logic [1:0] MODE_EVEN  = 2'd2;
	localparam logic [1:0] MODE_ODD   = 2'd3;

	typedef struct packed {
		logic inc;
		logic odd;
	} unit_ctrl_t;

endpackage

// ===== design/pst_ram.sv =====
// ----------------------------------------------------------------------------
// pst_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pst_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [$clog2(D)-1:0] wr_addr,
	input  logic [W-1:0]         wr_data,
	input  logic                 rd_en,
	input  logic [$clog2(D)-1:0] rd_addr,
	output logic [W-1:0]         rd_data
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

// ===== design/pst_unit.sv =====
// ----------------------------------------------------------------------------
// pst_unit: shared element arithmetic
// One 64-bit adder either increments a stored element or adds it to the
// running query sum when its parity matches.
// ----------------------------------------------------------------------------
module pst_unit (
	input  pst_pkg::unit_ctrl_t          ctrl,
	input  logic [pst_pkg::WORD_W-1:0]   word,
	input  logic [pst_pkg::VAL_W-1:0]    acc,
	output logic [pst_pkg::WORD_W-1:0]   new_word,
	output logic [pst_pkg::VAL_W-1:0]    acc_next
);
	import pst_pkg::*;

	logic             loaded;
	logic [VAL_W-1:0] value;
	logic             take;
	logic [VAL_W-1:0] op_a;
	logic [VAL_W-1:0] op_b;
	logic [VAL_W-1:0] sum;

	assign loaded = word[WORD_W-1];
	assign value  = word[VAL_W-1:0];
	assign take   = loaded && (value[0] == ctrl.odd);

	always_comb begin
		if (ctrl.inc) begin
			op_a = value;
			op_b = {{(VAL_W-1){1'b0}}, 1'b1};
		end else begin
			op_a = acc;
			op_b = take ? value : '0;
		end
	end

	assign sum      = op_a + op_b;
	// An element that was never loaded stays out of both sets.
	assign new_word = loaded ? {1'b1, sum} : word;
	assign acc_next = sum;
endmodule

// ===== design/parity_split_range_sum_tree.sv =====
// ----------------------------------------------------------------------------
// parity_split_range_sum_tree: range increment and parity range sums
// Elements live in one RAM word each (loaded flag and 64-bit value) and are
// visited one at a time by a small sequencer around a shared adder.
// ----------------------------------------------------------------------------
// A point write is written to the RAM in the decode state. A range increment
// visits each element in the clipped range in turn, as a read followed by a
// write-back through the single RAM port pair. A query reads its elements the
// same way, then passes through a done state to move its sum into the output
// register, and waits there while the previous result has not been taken.
// After reset, and after every write of element_count, a clearing pass over
// all 1024 words empties the RAM, during which no transaction is accepted.
module parity_split_range_sum_tree (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          element_count_we,
	input  logic [pst_pkg::CNT_W-1:0]     element_count,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [pst_pkg::IDX_W-1:0]     first_index,
	input  logic [pst_pkg::IDX_W-1:0]     last_index,
	input  logic signed [31:0]            new_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [63:0]            range_sum
);
	import pst_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_RD     = 3'd2;
	localparam logic [2:0] ST_EXE    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [1:0]        mode_q;
	logic [IDX_W-1:0]  lo_q;
	logic [IDX_W-1:0]  hi_q;
	logic [31:0]       val_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  end_q;
	logic [VAL_W-1:0]  acc_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  range_sum_q;

	logic [CNT_W-1:0]  cnt_clamped;
	logic [IDX_W-1:0]  last;
	logic [IDX_W-1:0]  end_idx;
	logic              result_load;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [WORD_W-1:0] rd_data;

	unit_ctrl_t        ctrl;
	logic [WORD_W-1:0] new_word;
	logic [VAL_W-1:0]  acc_next;

	always_comb begin
		cnt_clamped = count_q;
		if (count_q == '0) begin
			cnt_clamped = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_ELEMENTS)) begin
			cnt_clamped = CNT_W'(MAX_ELEMENTS);
		end
	end

	assign last    = IDX_W'(cnt_clamped - CNT_W'(1));
	assign end_idx = (hi_q < last) ? hi_q : last;

	assign ctrl.inc = (mode_q == MODE_INC);
	assign ctrl.odd = (mode_q == MODE_ODD);

	// The result moves to the output register once that register is free.
	assign result_load = (state_q == ST_DONE) && !element_count_we &&
		(!out_valid_q || out_ready);

	pst_unit u_unit (
		.ctrl     (ctrl),
		.word     (rd_data),
		.acc      (acc_q),
		.new_word (new_word),
		.acc_next (acc_next)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = new_word;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			ST_DECODE: begin
				wr_en   = (mode_q == MODE_WRITE) && (lo_q <= last);
				wr_addr = lo_q;
				wr_data = {1'b1, {32{val_q[31]}}, val_q};
			end
			ST_EXE: begin
				wr_en = ctrl.inc;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_en = (state_q == ST_RD);

	pst_ram #(
		.W (WORD_W),
		.D (MAX_ELEMENTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			count_q     <= CNT_W'(MAX_ELEMENTS);
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (element_count_we) begin
				count_q <= element_count;
				state_q <= ST_CLEAR;
				idx_q   <= '0;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == IDX_W'(MAX_ELEMENTS - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_valid) begin
							state_q <= ST_DECODE;
						end
					end
					ST_DECODE: begin
						acc_q <= '0;
						end_q <= end_idx;
						idx_q <= lo_q;
						if (mode_q == MODE_WRITE) begin
							state_q <= ST_IDLE;
						end else if (lo_q > end_idx) begin
							state_q <= ctrl.inc ? ST_IDLE : ST_DONE;
						end else begin
							state_q <= ST_RD;
						end
					end
					ST_RD: begin
						state_q <= ST_EXE;
					end
					ST_EXE: begin
						if (!ctrl.inc) begin
							acc_q <= acc_next;
						end
						if (idx_q == end_q) begin
							state_q <= ctrl.inc ? ST_IDLE : ST_DONE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_RD;
						end
					end
					ST_DONE: begin
						// The result waits here until the output register is free.
						if (result_load) begin
							range_sum_q <= acc_q;
							state_q     <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode;
			lo_q   <= first_index;
			hi_q   <= last_index;
			val_q  <= new_value;
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && !element_count_we;
	assign out_valid = out_valid_q;
	assign range_sum = range_sum_q;

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction accepted while another is in progress");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXE |-> idx_q <= end_q && idx_q <= last)
		else $error("element walk left the clipped range");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");

	a_inc_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXE && ctrl.inc |=> !$rose(out_valid_q))
		else $error("increment produced a result");
`endif
endmodule
